// ===== rtl/vccf_pkg.sv =====
// Package for the view cull and centroid follow block.
// Holds the item and result types, the datapath command and status types, and constants.
// Used by every module in rtl/; depends on nothing else.
`default_nettype none

package vccf_pkg;

  localparam int FRACTION_BITS = 16;

  // Serial divider geometry: 49 quotient bits, 40-bit divisor.
  localparam int DIV_BITS = 49;
  localparam int DIV_CNT_W = 6;
  localparam int REM_W = 40;

  // Zoom step is one hundredth of the zoom scale.
  localparam int ZOOM_DIVISOR = 100;

  // floor(z / 100) == (z * ZOOM_RECIP) >> ZOOM_RECIP_SHIFT for every 32-bit z.
  localparam logic [31:0] ZOOM_RECIP = 32'h51EB_851F;
  localparam int ZOOM_RECIP_SHIFT = 37;

  // Reset values of the configuration registers.
  localparam logic [31:0] ZOOM_RESET = 32'(1) << FRACTION_BITS;
  localparam logic [12:0] WIDTH_RESET = 13'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;

  typedef enum logic [2:0] {
    CFG_ZOOM_SCALE    = 3'd0,
    CFG_CAMERA_X      = 3'd1,
    CFG_CAMERA_Y      = 3'd2,
    CFG_SCREEN_WIDTH  = 3'd3,
    CFG_SCREEN_HEIGHT = 3'd4,
    CFG_AUTO_FOLLOW   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [47:0] body_x;
    logic signed [47:0] body_y;
    logic [31:0]        body_mass;
    logic [15:0]        body_radius;
    logic               frame_end;
  } body_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic [15:0]        screen_radius;
    logic signed [47:0] target_x;
    logic signed [47:0] target_y;
    logic [31:0]        target_zoom;
    logic               zoom_out;
    logic               last;
  } result_t;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MLO_X,
    OP_MHI_X,
    OP_DIV_CX,
    OP_WB_CX,
    OP_MLO_Y,
    OP_MHI_Y,
    OP_DIV_CY,
    OP_WB_CY,
    OP_LIM_X,
    OP_CMP_X,
    OP_LIM_Y,
    OP_CMP_Y,
    OP_DIV_SX,
    OP_WB_SX,
    OP_DIV_SY,
    OP_WB_SY,
    OP_DIV_R,
    OP_WB_R,
    OP_EMIT_PT,
    OP_MUL_Z,
    OP_WB_Z,
    OP_EMIT_SUM
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic sum_nz;
    logic visible;
    logic frame_end;
    logic auto_follow;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/vccf_div.sv =====
// Restoring serial divider, one quotient bit per cycle, 49 steps.
// Depends on vccf_pkg for its widths.
`default_nettype none

module vccf_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [vccf_pkg::REM_W-1:0]    rem_init_i,
  input  wire logic [vccf_pkg::DIV_BITS-1:0] dividend_i,
  input  wire logic [vccf_pkg::REM_W-1:0]    divisor_i,
  output logic                               done_o,
  output logic [vccf_pkg::DIV_BITS-1:0]      quot_o
);
  import vccf_pkg::*;

  logic [REM_W-1:0]     rem_q, rem_d;
  logic [REM_W-1:0]     dsr_q;
  logic [DIV_BITS-1:0]  sh_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [REM_W:0]       trial;
  logic                 qbit;

  // One restoring step: bring in the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem_q, sh_q[DIV_BITS-1]};
    qbit  = (trial >= {1'b0, dsr_q});
    rem_d = qbit ? REM_W'(trial - {1'b0, dsr_q}) : trial[REM_W-1:0];
  end

  // Step counter and completion flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_BITS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Remainder and the shift register that trades dividend bits for quotient bits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init_i;
      sh_q  <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= {sh_q[DIV_BITS-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = sh_q;

endmodule

`default_nettype wire

// ===== rtl/vccf_ctrl.sv =====
// Controller state machine that sequences the datapath for one body item.
// Depends on vccf_pkg for the command and status types.
`default_nettype none

module vccf_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire vccf_pkg::dp_status_t status_i,
  output vccf_pkg::dp_cmd_t         cmd_o
);
  import vccf_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MLO_X, ST_MHI_X, ST_DIV_CX, ST_WAIT_CX,
    ST_MLO_Y, ST_MHI_Y, ST_DIV_CY, ST_WAIT_CY,
    ST_LIM_X, ST_CMP_X, ST_LIM_Y, ST_CMP_Y, ST_CHK,
    ST_DIV_SX, ST_WAIT_SX, ST_DIV_SY, ST_WAIT_SY, ST_DIV_R, ST_WAIT_R,
    ST_EMIT_PT, ST_MUL_Z, ST_WB_Z, ST_EMIT_SUM
  } state_e;

  state_e state_q, state_d;
  state_e after_body;

  // Where to go once the body itself is done.
  always_comb begin
    if (!status_i.frame_end) begin
      after_body = ST_IDLE;
    end else if (status_i.auto_follow) begin
      after_body = ST_MUL_Z;
    end else begin
      after_body = ST_EMIT_SUM;
    end
  end

  // Command decode and next state.
  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_MLO_X;
        end
      end
      ST_MLO_X: begin
        if (status_i.sum_nz) begin
          cmd_o.op = OP_MLO_X;
          state_d  = ST_MHI_X;
        end else begin
          state_d = ST_LIM_X;
        end
      end
      ST_MHI_X: begin
        cmd_o.op = OP_MHI_X;
        state_d  = ST_DIV_CX;
      end
      ST_DIV_CX: begin
        cmd_o.op = OP_DIV_CX;
        state_d  = ST_WAIT_CX;
      end
      ST_WAIT_CX: begin
        if (status_i.div_done) begin
          cmd_o.op = OP_WB_CX;
          state_d  = ST_MLO_Y;
        end
      end
      ST_MLO_Y: begin
        cmd_o.op = OP_MLO_Y;
        state_d  = ST_MHI_Y;
      end
      ST_MHI_Y: begin
        cmd_o.op = OP_MHI_Y;
        state_d  = ST_DIV_CY;
      end
      ST_DIV_CY: begin
        cmd_o.op = OP_DIV_CY;
        state_d  = ST_WAIT_CY;
      end
      ST_WAIT_CY: begin
        if (status_i.div_done) begin
          cmd_o.op = OP_WB_CY;
          state_d  = ST_LIM_X;
        end
      end
      ST_LIM_X: begin
        cmd_o.op = OP_LIM_X;
        state_d  = ST_CMP_X;
      end
      ST_CMP_X: begin
        cmd_o.op = OP_CMP_X;
        state_d  = ST_LIM_Y;
      end
      ST_LIM_Y: begin
        cmd_o.op = OP_LIM_Y;
        state_d  = ST_CMP_Y;
      end
      ST_CMP_Y: begin
        cmd_o.op = OP_CMP_Y;
        state_d  = ST_CHK;
      end
      ST_CHK: begin
        state_d = status_i.visible ? ST_DIV_SX : after_body;
      end
      ST_DIV_SX: begin
        cmd_o.op = OP_DIV_SX;
        state_d  = ST_WAIT_SX;
      end
      ST_WAIT_SX: begin
        if (status_i.div_done) begin
          cmd_o.op = OP_WB_SX;
          state_d  = ST_DIV_SY;
        end
      end
      ST_DIV_SY: begin
        cmd_o.op = OP_DIV_SY;
        state_d  = ST_WAIT_SY;
      end
      ST_WAIT_SY: begin
        if (status_i.div_done) begin
          cmd_o.op = OP_WB_SY;
          state_d  = ST_DIV_R;
        end
      end
      ST_DIV_R: begin
        cmd_o.op = OP_DIV_R;
        state_d  = ST_WAIT_R;
      end
      ST_WAIT_R: begin
        if (status_i.div_done) begin
          cmd_o.op = OP_WB_R;
          state_d  = ST_EMIT_PT;
        end
      end
      ST_EMIT_PT: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_EMIT_PT;
          state_d  = after_body;
        end
      end
      ST_MUL_Z: begin
        cmd_o.op = OP_MUL_Z;
        state_d  = ST_WB_Z;
      end
      ST_WB_Z: begin
        cmd_o.op = OP_WB_Z;
        state_d  = ST_EMIT_SUM;
      end
      ST_EMIT_SUM: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_EMIT_SUM;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/vccf_dp.sv =====
// Datapath: configuration registers, frame accumulators, shared multiplier,
// shared serial divider and the output register. Depends on vccf_pkg and vccf_div.
`default_nettype none

module vccf_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire vccf_pkg::dp_cmd_t           cmd_i,
  output vccf_pkg::dp_status_t             status_o,
  input  wire vccf_pkg::body_t             in_body_i,
  input  wire logic                        cfg_valid_i,
  input  wire logic [2:0]                  cfg_index_i,
  input  wire logic [47:0]                 cfg_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output vccf_pkg::result_t                out_result_o
);
  import vccf_pkg::*;

  // Configuration.
  logic [31:0]        zoom_q;
  logic signed [47:0] cam_x_q, cam_y_q;
  logic [12:0]        width_q, height_q;
  logic               auto_q;

  // Item and frame state.
  logic [31:0]        m_q;
  logic [15:0]        r_q;
  logic               fe_q;
  logic [39:0]        mass_q;
  logic signed [47:0] cx_q, cy_q, held_x_q, held_y_q;
  logic               culled_q;
  logic [31:0]        tscale_q;
  logic signed [48:0] dcx_q, dcy_q, dx_q, dy_q;
  logic [80:0]        prod_q;
  logic               vis_x_q, vis_q;
  logic signed [15:0] sx_q, sy_q;
  logic [15:0]        rr_q;
  logic               out_valid_q;
  result_t            out_q;

  logic [31:0]        scale;
  logic [11:0]        hw, hh;
  logic [40:0]        sum_wide;
  logic [39:0]        sum_sat;
  logic [48:0]        abs_dcx, abs_dcy, abs_dx, abs_dy;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic [48:0]        lim;
  logic [48:0]        r_fix;
  logic               div_start, div_done;
  logic [REM_W-1:0]   div_rem_init, div_divisor;
  logic [DIV_BITS-1:0] div_dividend, quot;
  logic [31:0]        zoom_delta;
  logic [32:0]        zoom_up;
  logic               out_take;
  result_t            emit_res;

  function automatic logic [48:0] abs49(input logic signed [48:0] v);
    abs49 = v[48] ? 49'(-v) : 49'(v);
  endfunction

  // Applies a sign to a quotient and adds it to an offset, all in 51 bits.
  function automatic logic signed [50:0] add_signed(input logic signed [50:0] base,
                                                     input logic neg,
                                                     input logic [48:0] q);
    logic signed [50:0] sq;
    sq = $signed({2'b00, q});
    add_signed = neg ? base - sq : base + sq;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [50:0] v);
    if (v > 51'sd32767) begin
      sat16 = 16'sh7FFF;
    end else if (v < -51'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

  assign scale   = (zoom_q == '0) ? 32'd1 : zoom_q;
  assign hw      = width_q[12:1];
  assign hh      = height_q[12:1];
  assign abs_dcx = abs49(dcx_q);
  assign abs_dcy = abs49(dcy_q);
  assign abs_dx  = abs49(dx_q);
  assign abs_dy  = abs49(dy_q);
  assign r_fix   = 49'(r_q) << FRACTION_BITS;
  assign lim     = 49'(prod_q[43:0]) + r_fix;

  // Saturating running mass total.
  always_comb begin
    sum_wide = {1'b0, mass_q} + 41'(in_body_i.body_mass);
    sum_sat  = sum_wide[40] ? '1 : sum_wide[39:0];
  end

  // Shared 32x32 multiplier operand select.
  always_comb begin
    mul_a = '0;
    mul_b = m_q;
    case (cmd_i.op)
      OP_MLO_X: mul_a = abs_dcx[31:0];
      OP_MHI_X: mul_a = 32'(abs_dcx[48:32]);
      OP_MLO_Y: mul_a = abs_dcy[31:0];
      OP_MHI_Y: mul_a = 32'(abs_dcy[48:32]);
      OP_LIM_X: begin
        mul_a = 32'(hw);
        mul_b = scale;
      end
      OP_LIM_Y: begin
        mul_a = 32'(hh);
        mul_b = scale;
      end
      OP_MUL_Z: begin
        mul_a = zoom_q;
        mul_b = ZOOM_RECIP;
      end
      default: mul_a = '0;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Divider operand select.
  always_comb begin
    div_start    = 1'b1;
    div_rem_init = '0;
    div_dividend = '0;
    div_divisor  = 40'(scale);
    case (cmd_i.op)
      OP_DIV_CX, OP_DIV_CY: begin
        div_rem_init = 40'(prod_q[80:49]);
        div_dividend = prod_q[48:0];
        div_divisor  = mass_q;
      end
      OP_DIV_SX: div_dividend = abs_dx;
      OP_DIV_SY: div_dividend = abs_dy;
      OP_DIV_R:  div_dividend = r_fix;
      default: div_start = 1'b0;
    endcase
  end

  vccf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .rem_init_i (div_rem_init),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // One hundredth of the zoom scale, from the reciprocal product.
  assign zoom_delta = 32'(prod_q[63:ZOOM_RECIP_SHIFT]);
  assign zoom_up    = {1'b0, tscale_q} + {1'b0, zoom_delta};
  assign out_take   = out_valid_q && !out_stall_i;

  // Payload of a body point or of a frame summary.
  always_comb begin
    emit_res = '0;
    if (cmd_i.op == OP_EMIT_SUM) begin
      emit_res.kind        = 1'b1;
      emit_res.target_x    = held_x_q;
      emit_res.target_y    = held_y_q;
      emit_res.target_zoom = tscale_q;
      emit_res.zoom_out    = culled_q;
      emit_res.last        = 1'b1;
    end else begin
      emit_res.screen_x      = sx_q;
      emit_res.screen_y      = sy_q;
      emit_res.screen_radius = rr_q;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zoom_q   <= ZOOM_RESET;
      cam_x_q  <= '0;
      cam_y_q  <= '0;
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      auto_q   <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ZOOM_SCALE:    zoom_q   <= cfg_data_i[31:0];
        CFG_CAMERA_X:      cam_x_q  <= cfg_data_i;
        CFG_CAMERA_Y:      cam_y_q  <= cfg_data_i;
        CFG_SCREEN_WIDTH:  width_q  <= cfg_data_i[12:0];
        CFG_SCREEN_HEIGHT: height_q <= cfg_data_i[12:0];
        CFG_AUTO_FOLLOW:   auto_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Frame accumulators, camera target and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q      <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      held_x_q    <= '0;
      held_y_q    <= '0;
      culled_q    <= 1'b0;
      tscale_q    <= ZOOM_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_EMIT_PT || cmd_i.op == OP_EMIT_SUM) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_LOAD:  mass_q <= sum_sat;
        OP_WB_CX: cx_q <= 48'(add_signed(51'(cx_q), dcx_q[48], quot));
        OP_WB_CY: cy_q <= 48'(add_signed(51'(cy_q), dcy_q[48], quot));
        OP_CMP_Y: begin
          if (!(vis_x_q && (abs_dy < lim))) begin
            culled_q <= 1'b1;
          end
        end
        OP_WB_Z: begin
          held_x_q <= cx_q;
          held_y_q <= cy_q;
          if (culled_q) begin
            tscale_q <= zoom_up[32] ? '1 : zoom_up[31:0];
          end else begin
            tscale_q <= (tscale_q > zoom_delta) ? tscale_q - zoom_delta : '0;
          end
        end
        OP_EMIT_SUM: begin
          mass_q      <= '0;
          cx_q        <= '0;
          cy_q        <= '0;
          culled_q    <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Working registers and the output payload.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        m_q   <= in_body_i.body_mass;
        r_q   <= in_body_i.body_radius;
        fe_q  <= in_body_i.frame_end;
        dcx_q <= 49'(in_body_i.body_x) - 49'(cx_q);
        dcy_q <= 49'(in_body_i.body_y) - 49'(cy_q);
        dx_q  <= 49'(in_body_i.body_x) - 49'(cam_x_q);
        dy_q  <= 49'(in_body_i.body_y) - 49'(cam_y_q);
      end
      OP_MLO_X, OP_MLO_Y, OP_LIM_X, OP_LIM_Y, OP_MUL_Z: prod_q <= 81'(mul_p);
      OP_MHI_X, OP_MHI_Y: prod_q <= prod_q + (81'(mul_p) << 32);
      OP_CMP_X: vis_x_q <= (abs_dx < lim);
      OP_CMP_Y: vis_q <= vis_x_q && (abs_dy < lim);
      OP_WB_SX: sx_q <= sat16(add_signed(51'(hw), dx_q[48], quot));
      OP_WB_SY: sy_q <= sat16(add_signed(51'(hh), dy_q[48], quot));
      OP_WB_R: begin
        if (quot > 49'd65535) begin
          rr_q <= 16'hFFFF;
        end else if (quot == '0) begin
          rr_q <= 16'd1;
        end else begin
          rr_q <= quot[15:0];
        end
      end
      OP_EMIT_PT, OP_EMIT_SUM: out_q <= emit_res;
      default: ;
    endcase
  end

  // Status back to the controller.
  always_comb begin
    status_o.sum_nz      = (mass_q != '0);
    status_o.visible     = vis_q;
    status_o.frame_end   = fe_q;
    status_o.auto_follow = auto_q;
    status_o.div_done    = div_done;
    status_o.out_free    = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_q;

endmodule

`default_nettype wire

// ===== rtl/view_cull_and_centroid_follow_top.sv =====
// View cull and centroid follow, top level. One body item at a time. A visible body's point
// is offered once the body's work is done (the centroid steps are skipped while the total mass
// is zero); at a frame end a summary follows the body's work, after the zoom step in auto mode
// and directly in manual mode. Each division runs on the shared serial divider, up to five per
// body, and a stalled result holds the controller.
// Reset (rst_ni low, asynchronous) restores the registers and clears the frame.
`default_nettype none

module view_cull_and_centroid_follow_top (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire vccf_pkg::body_t   in_body_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output vccf_pkg::result_t      out_result_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [47:0]       cfg_data_i
);
  import vccf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Configuration is always taken.
  assign cfg_ready_o = 1'b1;

  vccf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  vccf_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_body_i    (in_body_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_result_o (out_result_o)
  );

endmodule

`default_nettype wire

// ===== rtl/vccf_chk.sv =====
// Port-level checker for the view cull block, bound to the top level.
// Depends on vccf_pkg for the result type.
`default_nettype none

module vccf_chk (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire vccf_pkg::result_t out_result_o
);
  import vccf_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped under stall");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_result_o))
    else $error("result changed under stall");

  // A summary always closes the frame and has a zero screen radius.
  a_sum_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_result_o.kind |->
      out_result_o.last && out_result_o.screen_radius == 16'd0)
    else $error("summary malformed");

  // A body point has a nonzero radius and no summary fields.
  a_pt_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_result_o.kind |->
      out_result_o.screen_radius != 16'd0 && !out_result_o.last &&
      !out_result_o.zoom_out && out_result_o.target_zoom == 32'd0)
    else $error("body point malformed");

endmodule

bind view_cull_and_centroid_follow_top vccf_chk u_vccf_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_result_o (out_result_o)
);

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the view cull and centroid follow block.
// Drives body items and register writes, predicts points and frame summaries, checks them.
// Depends on rtl/vccf_pkg.sv and rtl/view_cull_and_centroid_follow_top.sv.
`timescale 1ns / 100ps

module tb;
  import vccf_pkg::*;

  localparam longint unsigned MASS_MAX = 64'hFF_FFFF_FFFF;
  localparam int DRAIN_CYCLES = 500;
  localparam longint CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  body_t in_body = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  result_t out_result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;

  // Mirror of the block's registers and frame state.
  logic [31:0] zoom_scale_q = ZOOM_RESET;
  longint cam_x_q = 0;
  longint cam_y_q = 0;
  logic [12:0] scr_w_q = WIDTH_RESET;
  logic [12:0] scr_h_q = HEIGHT_RESET;
  logic follow_q = 1'b1;
  longint cen_x = 0;
  longint cen_y = 0;
  longint held_x = 0;
  longint held_y = 0;
  longint unsigned mass_sum = 0;
  longint unsigned zoom_target = 64'(ZOOM_RESET);
  logic culled_seen = 1'b0;

  result_t pending_results[$];
  int mismatches = 0;
  longint cycles = 0;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;

  view_cull_and_centroid_follow_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_body_i   (in_body),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_result_o(out_result),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // trunc(d * m / s), exact, with the sign of d.
  function automatic longint weighted_step(longint d, longint unsigned m, longint unsigned s);
    logic [127:0] mag;
    logic [127:0] q;
    mag = d < 0 ? 128'(-d) : 128'(d);
    q = (mag * 128'(m)) / 128'(s);
    return d < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint trunc_quot(longint d, longint unsigned s);
    longint unsigned mag;
    mag = d < 0 ? longint'(-d) : d;
    return d < 0 ? -longint'(mag / s) : longint'(mag / s);
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // Expected results of one accepted body, queued in order.
  function automatic void predict_body(body_t b);
    longint bx, by, dx, dy, limx, limy;
    longint unsigned m, r, s, hw, hh, sum, rr, delta;
    result_t res;
    bx = longint'(b.body_x);
    by = longint'(b.body_y);
    m = 64'(b.body_mass);
    r = 64'(b.body_radius);
    s = zoom_scale_q == 0 ? 1 : 64'(zoom_scale_q);
    hw = 64'(scr_w_q >> 1);
    hh = 64'(scr_h_q >> 1);
    sum = mass_sum + m;
    if (sum > MASS_MAX) sum = MASS_MAX;
    if (sum != 0) begin
      cen_x += weighted_step(bx - cen_x, m, sum);
      cen_y += weighted_step(by - cen_y, m, sum);
    end
    mass_sum = sum;
    dx = bx - cam_x_q;
    dy = by - cam_y_q;
    limx = longint'(hw * s + (r << FRACTION_BITS));
    limy = longint'(hh * s + (r << FRACTION_BITS));
    if (dx > -limx && dx < limx && dy > -limy && dy < limy) begin
      rr = (r << FRACTION_BITS) / s;
      if (rr > 65535) rr = 65535;
      if (rr < 1) rr = 1;
      res = '0;
      res.screen_x = clamp16(longint'(hw) + trunc_quot(dx, s));
      res.screen_y = clamp16(longint'(hh) + trunc_quot(dy, s));
      res.screen_radius = rr[15:0];
      pending_results.insert(pending_results.size(), res);
    end else begin
      culled_seen = 1'b1;
    end
    if (b.frame_end) begin
      // Auto mode moves the target to the centroid and steps the scale.
      if (follow_q) begin
        delta = 64'(zoom_scale_q) / ZOOM_DIVISOR;
        held_x = cen_x;
        held_y = cen_y;
        if (culled_seen)
          zoom_target = zoom_target + delta > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : zoom_target + delta;
        else
          zoom_target = zoom_target > delta ? zoom_target - delta : 0;
      end
      res = '0;
      res.kind = 1'b1;
      res.target_x = held_x[47:0];
      res.target_y = held_y[47:0];
      res.target_zoom = zoom_target[31:0];
      res.zoom_out = culled_seen;
      res.last = 1'b1;
      pending_results.insert(pending_results.size(), res);
      cen_x = 0;
      cen_y = 0;
      mass_sum = 0;
      culled_seen = 1'b0;
    end
  endfunction

  // Result side: random stall and comparison with the oldest expected item.
  always @(posedge clk) begin
    result_t exp_r;
    logic bad;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_result);
      end else begin
        exp_r = pending_results.pop_front();
        bad = (out_result.kind !== exp_r.kind) || (out_result.screen_x !== exp_r.screen_x) ||
              (out_result.screen_y !== exp_r.screen_y) ||
              (out_result.screen_radius !== exp_r.screen_radius) ||
              (out_result.target_x !== exp_r.target_x) ||
              (out_result.target_y !== exp_r.target_y) ||
              (out_result.target_zoom !== exp_r.target_zoom) ||
              (out_result.zoom_out !== exp_r.zoom_out) || (out_result.last !== exp_r.last);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", exp_r, out_result);
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
  end

  // Send one body item, with an optional idle gap first.
  task automatic send_body(body_t b);
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_body <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_body(b);
  endtask

  task automatic wait_results_done();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Let the block go idle, then write one register.
  task automatic write_reg(cfg_idx_e idx, logic [47:0] data);
    in_valid <= 1'b0;
    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ZOOM_SCALE:    zoom_scale_q = data[31:0];
      CFG_CAMERA_X:      cam_x_q = longint'(signed'(data));
      CFG_CAMERA_Y:      cam_y_q = longint'(signed'(data));
      CFG_SCREEN_WIDTH:  scr_w_q = data[12:0];
      CFG_SCREEN_HEIGHT: scr_h_q = data[12:0];
      CFG_AUTO_FOLLOW:   follow_q = data[0];
      default: ;
    endcase
  endtask

  function automatic body_t body_of(longint x, longint y, logic [31:0] m, logic [15:0] r,
                                    logic fe);
    body_t b;
    b.body_x = x[47:0];
    b.body_y = y[47:0];
    b.body_mass = m;
    b.body_radius = r;
    b.frame_end = fe;
    return b;
  endfunction

  // Coordinate near the window: a random pixel offset around the camera.
  function automatic longint near_coord(longint cam, logic [12:0] span);
    longint unsigned s;
    longint reach;
    s = zoom_scale_q == 0 ? 1 : 64'(zoom_scale_q);
    reach = longint'(span >> 1) + 8;
    return cam + ($signed($urandom_range(0, 32'(2 * reach))) - reach) * longint'(s) +
           longint'($urandom_range(0, 32'(s - 1)));
  endfunction

  function automatic body_t random_body(logic fe);
    body_t b;
    int pick;
    if ($urandom_range(0, 99) < 85) begin
      b.body_x = 48'(near_coord(cam_x_q, scr_w_q));
      b.body_y = 48'(near_coord(cam_y_q, scr_h_q));
    end else begin
      b.body_x = 48'({$urandom, $urandom});
      b.body_y = 48'({$urandom, $urandom});
    end
    pick = $urandom_range(0, 9);
    b.body_mass = pick == 0 ? 32'd0 : pick == 1 ? 32'hFFFF_FFFF :
                  pick < 5 ? $urandom : $urandom_range(1, 1000);
    pick = $urandom_range(0, 9);
    b.body_radius = pick == 0 ? 16'hFFFF : pick < 3 ? 16'($urandom) :
                    16'($urandom_range(0, 20));
    b.frame_end = fe;
    return b;
  endfunction

  // Reset-value registers: single-body frames, a zero mass frame and a two-body frame.
  task automatic test_reset_values();
    send_body(body_of(0, 0, 1, 0, 1'b1));
    send_body(body_of(0, 0, 0, 3, 1'b1));
    send_body(body_of(100 << 16, -(50 << 16), 7, 1, 1'b0));
    send_body(body_of(-(1000 << 16), 0, 32'hFFFF_FFFF, 65535, 1'b1));
  endtask

  // Window edges, extreme coordinates and radii.
  task automatic test_window_edges();
    longint limx;
    write_reg(CFG_CAMERA_X, 48'(1000 << 16));
    write_reg(CFG_CAMERA_Y, 48'(-(200 << 16)));
    limx = 320 * 65536 + (2 << 16);
    send_body(body_of(cam_x_q + limx, cam_y_q, 5, 2, 1'b0));
    send_body(body_of(cam_x_q + limx - 1, cam_y_q, 5, 2, 1'b0));
    send_body(body_of(cam_x_q - limx + 1, cam_y_q, 5, 2, 1'b0));
    send_body(body_of(cam_x_q - limx, cam_y_q, 5, 2, 1'b1));
    send_body(body_of(cam_x_q, cam_y_q + 240 * 65536 + (2 << 16) - 1, 9, 2, 1'b0));
    send_body(body_of(cam_x_q, cam_y_q - 240 * 65536 - (2 << 16), 9, 2, 1'b1));
    send_body(body_of(64'sh7FFF_FFFF_FFFF, 64'sh7FFF_FFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0));
    send_body(body_of(-64'sh8000_0000_0000, -64'sh8000_0000_0000, 32'hFFFF_FFFF, 65535,
                      1'b1));
    send_body(body_of(cam_x_q, cam_y_q, 0, 65535, 1'b1));
  endtask

  // Manual mode keeps the held target; zero zoom scale acts as one.
  task automatic test_manual_and_zero_zoom();
    write_reg(CFG_AUTO_FOLLOW, 48'd0);
    send_body(body_of(5 << 16, 5 << 16, 10, 1, 1'b0));
    send_body(body_of(1 << 30, 0, 10, 1, 1'b1));
    write_reg(CFG_ZOOM_SCALE, 48'd0);
    write_reg(CFG_SCREEN_WIDTH, 48'd0);
    write_reg(CFG_SCREEN_HEIGHT, 48'd8191);
    send_body(body_of(cam_x_q + 3, cam_y_q - 7, 2, 0, 1'b1));
    write_reg(CFG_AUTO_FOLLOW, 48'd1);
    send_body(body_of(cam_x_q, cam_y_q, 4, 1, 1'b1));
  endtask

  // Random frames under one register setting and one idling mode.
  task automatic random_phase(logic [31:0] zoom, logic [47:0] cx, logic [47:0] cy,
                              logic [12:0] w, logic [12:0] h, logic follow, int idle_mode,
                              int n_items);
    int sent;
    int flen;
    write_reg(CFG_ZOOM_SCALE, 48'(zoom));
    write_reg(CFG_CAMERA_X, cx);
    write_reg(CFG_CAMERA_Y, cy);
    write_reg(CFG_SCREEN_WIDTH, 48'(w));
    write_reg(CFG_SCREEN_HEIGHT, 48'(h));
    write_reg(CFG_AUTO_FOLLOW, 48'(follow));
    case (idle_mode)
      0: begin snd_idle_pct = 0; rcv_stall_pct = 0; end
      1: begin snd_idle_pct = 55; rcv_stall_pct = 0; end
      2: begin snd_idle_pct = 0; rcv_stall_pct = 55; end
      default: begin snd_idle_pct = 27; rcv_stall_pct = 27; end
    endcase
    sent = 0;
    while (sent < n_items) begin
      flen = $urandom_range(1, 6);
      for (int k = 0; k < flen; k++) begin
        send_body(random_body(k == flen - 1 || $urandom_range(0, 19) == 0));
        sent++;
      end
      // Hold off once per phase until everything has come back.
      if (sent > n_items / 2 && sent - flen <= n_items / 2) begin
        in_valid <= 1'b0;
        wait_results_done();
      end
    end
  endtask

  task automatic test_random();
    random_phase(ZOOM_RESET, 48'd0, 48'd0, WIDTH_RESET, HEIGHT_RESET, 1'b1, 0, 142);
    random_phase(32'd1, 48'h0000_1234_5678, 48'hFFFF_F000_0000, 13'd4096, 13'd4096, 1'b1,
                 1, 142);
    random_phase(32'hFFFF_FFFF, 48'h7FFF_0000_0000, 48'h8000_0000_0000, 13'd1, 13'd1, 1'b1,
                 2, 142);
    random_phase(32'd3 << 14, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                 13'd800, 13'd600, 1'b0, 3, 142);
    random_phase(32'd0, 48'd0, 48'd0, 13'd8191, 13'd2, 1'b1, 1, 142);
    random_phase(32'h0010_0000, 48'h0000_0001_0000, 48'd0, 13'd320, 13'd240, 1'b1, 3, 142);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_window_edges();
    test_manual_and_zero_zoom();
    test_random();
    in_valid <= 1'b0;
    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
